>>> design/lpcs_pkg.sv
`timescale 1ns / 1ps
package lpcs_pkg;

  typedef logic signed [15:0] coef_t;

  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic {
    CFG_DATA_LENGTH   = 1'b0,
    CFG_FRAME_SAMPLES = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH0,
    ST_FETCH1,
    ST_FETCH2,
    ST_EMIT,
    ST_SYNTH
  } ctl_state_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_EXC,
    L_FMUL,
    L_FACC,
    L_BMUL,
    L_BACC
  } lat_state_t;

  typedef struct packed {
    logic start;
    logic clear;
  } lat_ctl_t;

  // field order within a frame
  localparam logic [3:0] F_ENERGY = 4'd0;
  localparam logic [3:0] F_REPEAT = 4'd1;
  localparam logic [3:0] F_PITCH  = 4'd2;
  localparam logic [3:0] F_K1     = 4'd3;
  localparam logic [3:0] F_K2     = 4'd4;
  localparam logic [3:0] F_K3     = 4'd5;
  localparam logic [3:0] F_K4     = 4'd6;
  localparam logic [3:0] F_K10    = 4'd12;

  localparam logic [3:0] E_SILENCE = 4'd0;
  localparam logic [3:0] E_STOP    = 4'd15;

  localparam logic [15:0] LFSR_TAPS    = 16'hB800;
  localparam logic [15:0] LFSR_SEED    = 16'h0001;
  localparam int          CHIRP_LENGTH = 41;
  localparam logic signed [15:0] CLAMP_HI = 16'sd511;
  localparam logic signed [15:0] CLAMP_LO = -16'sd512;
  localparam logic [9:0]  FRAME_SAMPLES_RST = 10'd200;

  localparam logic [2:0] FIELD_W [13] = '{
    3'd4, 3'd1, 3'd6, 3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3};

  localparam logic [7:0] ENERGY_ROM [16] = '{
    8'h00, 8'h02, 8'h03, 8'h04, 8'h05, 8'h07, 8'h0a, 8'h0f,
    8'h14, 8'h20, 8'h29, 8'h39, 8'h51, 8'h72, 8'ha1, 8'hff};

  localparam logic [7:0] PITCH_ROM [64] = '{
    8'h00, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16,
    8'h17, 8'h18, 8'h19, 8'h1a, 8'h1b, 8'h1c, 8'h1d, 8'h1e,
    8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2d, 8'h2f, 8'h31,
    8'h33, 8'h35, 8'h36, 8'h39, 8'h3b, 8'h3d, 8'h3f, 8'h42,
    8'h45, 8'h47, 8'h49, 8'h4d, 8'h4f, 8'h51, 8'h55, 8'h57,
    8'h5c, 8'h5f, 8'h63, 8'h66, 8'h6a, 8'h6e, 8'h73, 8'h77,
    8'h7b, 8'h80, 8'h85, 8'h8a, 8'h8f, 8'h95, 8'h9a, 8'ha0};

  localparam logic [15:0] K1_ROM [32] = '{
    16'h82c0, 16'h8380, 16'h83c0, 16'h8440, 16'h84c0, 16'h8540, 16'h8600, 16'h8780,
    16'h8880, 16'h8980, 16'h8ac0, 16'h8c00, 16'h8d40, 16'h8f00, 16'h90c0, 16'h92c0,
    16'h9900, 16'ha140, 16'hab80, 16'hb840, 16'hc740, 16'hd8c0, 16'hebc0, 16'h0000,
    16'h1440, 16'h2740, 16'h38c0, 16'h47c0, 16'h5480, 16'h5ec0, 16'h6700, 16'h6d40};

  localparam logic [15:0] K2_ROM [32] = '{
    16'hae00, 16'hb480, 16'hbb80, 16'hc340, 16'hcb80, 16'hd440, 16'hddc0, 16'he780,
    16'hf180, 16'hfbc0, 16'h0600, 16'h1040, 16'h1a40, 16'h2400, 16'h2d40, 16'h3600,
    16'h3e40, 16'h45c0, 16'h4cc0, 16'h5300, 16'h5880, 16'h5dc0, 16'h6240, 16'h6640,
    16'h69c0, 16'h6cc0, 16'h6f80, 16'h71c0, 16'h73c0, 16'h7580, 16'h7700, 16'h7e80};

  localparam logic [7:0] NARROW_ROM [8][16] = '{
    '{8'h92, 8'h9f, 8'had, 8'hba, 8'hc8, 8'hd5, 8'he3, 8'hf0,
      8'hfe, 8'h0b, 8'h19, 8'h26, 8'h34, 8'h41, 8'h4f, 8'h5c},
    '{8'hae, 8'hbc, 8'hca, 8'hd8, 8'he6, 8'hf4, 8'h01, 8'h0f,
      8'h1d, 8'h2b, 8'h39, 8'h47, 8'h55, 8'h63, 8'h71, 8'h7e},
    '{8'hae, 8'hba, 8'hc5, 8'hd1, 8'hdd, 8'he8, 8'hf4, 8'hff,
      8'h0b, 8'h17, 8'h22, 8'h2e, 8'h39, 8'h45, 8'h51, 8'h5c},
    '{8'hc0, 8'hcb, 8'hd6, 8'he1, 8'hec, 8'hf7, 8'h03, 8'h0e,
      8'h19, 8'h24, 8'h2f, 8'h3a, 8'h45, 8'h50, 8'h5b, 8'h66},
    '{8'hb3, 8'hbf, 8'hcb, 8'hd7, 8'he3, 8'hef, 8'hfb, 8'h07,
      8'h13, 8'h1f, 8'h2b, 8'h37, 8'h43, 8'h4f, 8'h5a, 8'h66},
    '{8'hc0, 8'hd8, 8'hf0, 8'h07, 8'h1f, 8'h37, 8'h4f, 8'h66,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hc0, 8'hd4, 8'he8, 8'hfc, 8'h10, 8'h25, 8'h39, 8'h4d,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hcd, 8'hdf, 8'hf1, 8'h04, 8'h16, 8'h28, 8'h3b, 8'h4d,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}};

  localparam logic [7:0] CHIRP_ROM [CHIRP_LENGTH] = '{
    8'h00, 8'h2a, 8'hd4, 8'h32, 8'hb2, 8'h12, 8'h25, 8'h14, 8'h02, 8'he1, 8'hc5,
    8'h02, 8'h5f, 8'h5a, 8'h05, 8'h0f, 8'h26, 8'hfc, 8'ha5, 8'ha5, 8'hd6, 8'hdd,
    8'hdc, 8'hfc, 8'h25, 8'h2b, 8'h22, 8'h21, 8'h0f, 8'hff, 8'hf8, 8'hee, 8'hed,
    8'hef, 8'hf7, 8'hf6, 8'hfa, 8'h00, 8'h03, 8'h02, 8'h01};

endpackage

>>> design/lpcs_bitmem.sv
`timescale 1ns / 1ps
module lpcs_bitmem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/lpcs_lattice.sv
`timescale 1ns / 1ps
module lpcs_lattice (
  input  logic                 clk,
  input  logic                 rst,
  input  lpcs_pkg::lat_ctl_t   ctl,
  input  logic [7:0]           energy,
  input  logic [7:0]           pitch,
  input  lpcs_pkg::coef_t      k_coef [10],
  output logic                 done,
  output logic signed [9:0]    sample
);
  import lpcs_pkg::*;

  lat_state_t         lstate;
  logic [3:0]         stage;
  logic signed [15:0] acc;
  logic signed [31:0] prod;
  logic               sh15;
  logic signed [15:0] dly [10];
  logic signed [15:0] u_r [9];
  logic [7:0]         pcnt;
  logic [15:0]        lfsr;

  logic [3:0]         stage_m1;
  logic signed [15:0] mul_k, mul_x;
  logic signed [15:0] prod_sh, diff, clamped;
  logic [7:0]         pcnt_next;
  logic [15:0]        chirp_prod;
  logic [15:0]        lfsr_next;
  logic signed [15:0] exc;

  always_comb begin
    stage_m1 = stage - 4'd1;
    if (lstate == L_FMUL) begin
      mul_k = k_coef[stage];
      mul_x = dly[stage];
    end else begin
      mul_k = k_coef[stage_m1];
      mul_x = u_r[stage_m1];
    end
    prod_sh = sh15 ? 16'(prod >>> 15) : 16'(prod >>> 7);
    diff = acc - prod_sh;
    if (diff > CLAMP_HI) clamped = CLAMP_HI;
    else if (diff < CLAMP_LO) clamped = CLAMP_LO;
    else clamped = diff;

    pcnt_next = (pcnt < pitch) ? pcnt + 8'd1 : 8'd0;
    chirp_prod = (pcnt_next < 8'(CHIRP_LENGTH))
               ? CHIRP_ROM[pcnt_next[5:0]] * energy : 16'd0;
    lfsr_next = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);
    if (pitch != 8'd0) exc = {8'h00, chirp_prod[15:8]};
    else if (lfsr_next[0]) exc = {8'h00, energy};
    else exc = -$signed({8'h00, energy});
  end

  assign done = (lstate == L_IDLE);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      lstate <= L_IDLE;
      pcnt   <= 8'd0;
      lfsr   <= LFSR_SEED;
      sample <= '0;
      for (int i = 0; i < 10; i++) dly[i] <= '0;
    end else begin
      case (lstate)
        L_IDLE: begin
          if (ctl.start) lstate <= L_EXC;
        end
        L_EXC: begin
          if (pitch != 8'd0) pcnt <= pcnt_next;
          else lfsr <= lfsr_next;
          acc    <= exc;
          stage  <= 4'd9;
          lstate <= L_FMUL;
        end
        L_FMUL: begin
          prod   <= mul_k * mul_x;
          sh15   <= (stage < 4'd2);
          lstate <= L_FACC;
        end
        L_FACC: begin
          if (stage == 4'd0) begin
            u_r[0] <= clamped;
            stage  <= 4'd9;
            lstate <= L_BMUL;
          end else begin
            if (stage <= 4'd8) u_r[stage] <= diff;
            acc    <= diff;
            stage  <= stage_m1;
            lstate <= L_FMUL;
          end
        end
        L_BMUL: begin
          prod   <= mul_k * mul_x;
          sh15   <= (stage <= 4'd2);
          lstate <= L_BACC;
        end
        L_BACC: begin
          // delay[i] takes the old delay[i-1], which is updated later
          dly[stage] <= dly[stage_m1] + prod_sh;
          if (stage == 4'd1) begin
            dly[0] <= u_r[0];
            sample <= u_r[0][9:0];
            lstate <= L_IDLE;
          end else begin
            stage  <= stage_m1;
            lstate <= L_BMUL;
          end
        end
        default: lstate <= L_IDLE;
      endcase
    end
  end

endmodule

>>> design/lpc_speech_lattice_synth.sv
`timescale 1ns / 1ps
// LPC speech synthesizer. Write items (func 0) store bitstream bytes, tick items
// (func 1) return one sample each, restart items (func 2) rewind decoding and clear
// the filter. Writes and restarts give no result. A tick runs from accept through
// the output register load, then the ten-stage lattice run on one shared 16x16
// multiplier (an excitation step, then a multiply and an accumulate step per
// forward stage and per backward stage), and back to idle before the next accept.
// A tick that starts a new frame first decodes up to 13 fields, each through the
// FETCH0, FETCH1 and FETCH2 states on the single bitstream read port. A full
// output register holds the tick in the output load step until m_tready frees it.
// BITSTREAM_BYTES must be a power of two; write addresses wrap modulo it. No
// clearing pass is needed after reset.
module lpc_speech_lattice_synth #(
  parameter int BITSTREAM_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] func, [13:2] byte_address, [21:14] byte_value, [23:22] zero
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] sample
  output logic [15:0] m_tdata,
  // [0] ended
  output logic        m_tuser
);
  import lpcs_pkg::*;

  localparam int AW = $clog2(BITSTREAM_BYTES);
  localparam int PW = $clog2(BITSTREAM_BYTES + 1);
  localparam int LW = (PW > 13) ? PW : 13;
  localparam logic [LW-1:0] MEM_BYTES = LW'(BITSTREAM_BYTES);

  ctl_state_t  state, state_next;
  logic [12:0] data_length;
  logic [9:0]  frame_samples;
  logic [PW-1:0] pos;
  logic [2:0]  bitpos;
  logic [7:0]  energy, pitch;
  logic        rep;
  logic [3:0]  fidx;
  logic [7:0]  b0;
  logic [9:0]  samples_left;
  logic        stopped;
  logic        em_ended;
  coef_t       k1, k2;
  logic [7:0]  kn [8];

  logic        s_acc;
  func_t       func;
  logic [11:0] byte_address;
  logic [7:0]  byte_value;
  logic [AW-1:0] mem_raddr;
  logic [7:0]  mem_rdata;
  logic        mem_we;
  logic [LW-1:0] eff_len, pos_l, pos_l1;
  logic        have_data, use_b1;
  logic [2:0]  fw;
  logic [3:0]  bsum;
  logic [15:0] word, shifted;
  logic [5:0]  fval, val;
  logic [2:0]  nidx;
  logic        fld_done, fld_stop;
  logic        out_free;
  lat_ctl_t    lat_ctl;
  logic        lat_done;
  logic signed [9:0] lat_sample;
  coef_t       k_coef [10];

  function automatic logic [7:0] rev8(input logic [7:0] a);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = a[i];
    return r;
  endfunction

  assign func         = func_t'(s_tdata[1:0]);
  assign byte_address = s_tdata[13:2];
  assign byte_value   = s_tdata[21:14];
  assign s_tready     = (state == ST_IDLE);
  assign s_acc        = s_tvalid && s_tready;
  assign mem_we       = s_acc && (func == FUNC_WRITE);
  assign out_free     = !m_tvalid || m_tready;

  always_comb begin
    eff_len   = (LW'(data_length) > MEM_BYTES) ? MEM_BYTES : LW'(data_length);
    pos_l     = LW'(pos);
    pos_l1    = pos_l + LW'(1);
    have_data = pos_l < eff_len;
    fw        = FIELD_W[fidx];
    bsum      = {1'b0, bitpos} + {1'b0, fw};
    use_b1    = (bsum > 4'd8) && (pos_l1 < eff_len);
    word      = {rev8(b0), use_b1 ? rev8(mem_rdata) : 8'h00};
    shifted   = word << bitpos;
    fval      = shifted[15:10] >> (3'd6 - fw);
    val       = have_data ? fval : 6'd0;
    nidx      = 3'(fidx - F_K3);
    mem_raddr = (state == ST_FETCH0) ? AW'(pos) : AW'(pos_l1);

    fld_done = 1'b0;
    fld_stop = 1'b0;
    case (fidx)
      F_ENERGY: begin
        if (val[3:0] == E_SILENCE) fld_done = 1'b1;
        else if (val[3:0] == E_STOP) fld_stop = 1'b1;
      end
      F_PITCH:  fld_done = rep;
      F_K4:     fld_done = (pitch == 8'd0);
      F_K10:    fld_done = 1'b1;
      default:  fld_done = 1'b0;
    endcase
  end

  // next state and strobes
  always_comb begin
    state_next    = state;
    lat_ctl.start = 1'b0;
    lat_ctl.clear = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          case (func)
            FUNC_TICK: begin
              if (samples_left != 10'd0 || stopped || !have_data) state_next = ST_EMIT;
              else state_next = ST_FETCH0;
            end
            FUNC_RESTART: lat_ctl.clear = 1'b1;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_FETCH0: state_next = ST_FETCH1;
      ST_FETCH1: state_next = ST_FETCH2;
      ST_FETCH2: state_next = (fld_done || fld_stop) ? ST_EMIT : ST_FETCH0;
      ST_EMIT: begin
        if (out_free) begin
          lat_ctl.start = !em_ended;
          state_next    = em_ended ? ST_IDLE : ST_SYNTH;
        end
      end
      ST_SYNTH: if (lat_done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_length   <= '0;
      frame_samples <= FRAME_SAMPLES_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DATA_LENGTH:   data_length   <= cfg_data;
        CFG_FRAME_SAMPLES: frame_samples <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s_acc && func == FUNC_RESTART)) begin
      pos          <= '0;
      bitpos       <= '0;
      energy       <= '0;
      pitch        <= '0;
      k1           <= '0;
      k2           <= '0;
      for (int i = 0; i < 8; i++) kn[i] <= '0;
      samples_left <= '0;
      stopped      <= 1'b0;
      em_ended     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_acc && func == FUNC_TICK) begin
            em_ended <= (samples_left == 10'd0) && (stopped || !have_data);
            fidx     <= F_ENERGY;
          end
        end
        ST_FETCH1: b0 <= mem_rdata;
        ST_FETCH2: begin
          if (have_data) begin
            if (bsum >= 4'd8) pos <= pos + PW'(1);
            bitpos <= bsum[2:0];
          end
          fidx <= fidx + 4'd1;
          case (fidx)
            // stop code zeroes the energy
            F_ENERGY: energy <= fld_stop ? 8'h00 : ENERGY_ROM[val[3:0]];
            F_REPEAT: rep    <= val[0];
            F_PITCH:  pitch  <= PITCH_ROM[val];
            F_K1:     k1     <= K1_ROM[val[4:0]];
            F_K2:     k2     <= K2_ROM[val[4:0]];
            default:  kn[nidx] <= NARROW_ROM[nidx][val[3:0]];
          endcase
          if (fld_stop) begin
            k1       <= '0;
            k2       <= '0;
            for (int i = 0; i < 8; i++) kn[i] <= '0;
            stopped  <= 1'b1;
            em_ended <= 1'b1;
          end else if (fld_done) begin
            samples_left <= (frame_samples != 10'd0) ? frame_samples : 10'd1;
            em_ended     <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (out_free && !em_ended) samples_left <= samples_left - 10'd1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= em_ended ? 16'h0000 : {lat_sample, 6'b000000};
      m_tuser  <= em_ended;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    k_coef[0] = k1;
    k_coef[1] = k2;
    for (int i = 0; i < 8; i++) k_coef[i+2] = {{8{kn[i][7]}}, kn[i]};
  end

  lpcs_bitmem #(
    .DEPTH (BITSTREAM_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(byte_address)),
    .wdata (byte_value),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lpcs_lattice u_lat (
    .clk    (clk),
    .rst    (rst),
    .ctl    (lat_ctl),
    .energy (energy),
    .pitch  (pitch),
    .k_coef (k_coef),
    .done   (lat_done),
    .sample (lat_sample)
  );

endmodule
